// ===== design/lsp_pkg.sv =====
// lsp_pkg: shared constants, register codes and types of the lidar point converter
// no dependencies; imported by every module of the block

package lsp_pkg;

  localparam int MAX_BEAM_INDEX_DEF = 1080;
  localparam int PAN_STEPS_DEF      = 7000;
  localparam int MAX_ROWS_DEF       = 4096;
  localparam int BEAMS_PER_TURN     = 1440;

  // angle magnitude fed to the trig units, taken apart one digit a stage
  localparam int MAG_W        = 28;
  localparam int DIGIT_W      = 4;
  localparam int MOD_STAGES   = MAG_W / DIGIT_W;
  localparam int PHASE_STAGES = 32 / DIGIT_W;
  localparam int HORNER_SLOTS = 6;
  localparam int TRIG_LAT     = MOD_STAGES + 1 + PHASE_STAGES + 2 + 3 * HORNER_SLOTS + 1;

  localparam int QUEUE_DEPTH = 4;
  localparam int ADDR_W      = 5;

  localparam logic [15:0] GATE_LOW_MM  = 16'd100;
  localparam logic [15:0] GATE_HIGH_MM = 16'd30000;
  localparam logic [16:0] COORD_LIMIT  = 17'd65535;

  typedef enum logic [2:0] {
    REG_START_PAN = 3'd0,
    REG_PAN_INC   = 3'd1,
    REG_ROWS      = 3'd2,
    REG_FRONT     = 3'd3,
    REG_MIN_BEAM  = 3'd4,
    REG_MAX_BEAM  = 3'd5,
    REG_GATE_EN   = 3'd6
  } reg_idx_t;

  typedef struct packed {
    logic signed [15:0] start_pan_steps;
    logic signed [15:0] pan_step_increment;
    logic [12:0]        rows_in_scan;
    logic [10:0]        front_beam;
    logic [10:0]        min_beam;
    logic [10:0]        max_beam;
    logic               gate_enable;
  } cfg_t;

  typedef struct packed {
    logic [15:0]      range_mm;
    logic [12:0]      prow;
    logic [10:0]      col;
    logic             gated;
    logic             second;
    logic [MAG_W-1:0] pan_mag;
    logic             pan_neg;
    logic [10:0]      beam_mag;
  } item_t;

endpackage

// ===== design/lsp_front.sv =====
// lsp_front: takes range requests, drops the front beam and beams outside the window and classifies the rest
// depends on lsp_pkg (cfg_t, item_t, gate limits)

module lsp_front #(
  parameter int MAX_BEAM_INDEX = lsp_pkg::MAX_BEAM_INDEX_DEF,
  parameter int MAX_ROWS       = lsp_pkg::MAX_ROWS_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  logic [15:0]    range_mm,
  input  logic [10:0]    beam_index,
  input  logic [11:0]    row_index,
  input  lsp_pkg::cfg_t  cfg,
  input  logic           q_ready,
  output logic           q_push,
  output lsp_pkg::item_t q_item
);
  import lsp_pkg::*;

  logic               drop;
  logic               second;
  logic [10:0]        delta;
  logic [12:0]        rows;
  logic [13:0]        prow_sum;
  logic [12:0]        prow;
  logic signed [28:0] prod;
  logic signed [28:0] pos;
  logic               gated;
  item_t              item;

  logic  f_valid;
  logic  f_keep;
  item_t f_item;

  always_comb begin
    drop = (beam_index == cfg.front_beam) || (beam_index < cfg.min_beam) ||
           (beam_index > cfg.max_beam) || ({1'b0, beam_index} > 12'(MAX_BEAM_INDEX));
    second = beam_index > cfg.front_beam;
    delta  = second ? beam_index - cfg.front_beam : cfg.front_beam - beam_index;
    rows   = ({4'd0, cfg.rows_in_scan} > 17'(MAX_ROWS)) ? 13'(MAX_ROWS) : cfg.rows_in_scan;
    prow_sum = {2'd0, row_index} + {1'b0, rows};
    if (!second) begin
      prow = {1'b0, row_index};
    end else if (prow_sum > 14'd8191) begin
      prow = 13'd8191;
    end else begin
      prow = prow_sum[12:0];
    end
    prod = $signed({1'b0, row_index}) * cfg.pan_step_increment;
    pos  = prod + {{13{cfg.start_pan_steps[15]}}, cfg.start_pan_steps};
    gated = cfg.gate_enable && !(range_mm > GATE_LOW_MM && range_mm < GATE_HIGH_MM);

    item.range_mm = range_mm;
    item.prow     = prow;
    item.col      = delta - 11'd1;
    item.gated    = gated;
    item.second   = second;
    // the pan angle is minus the position, so a positive position wraps from below
    item.pan_mag  = pos[28] ? 28'(-pos) : 28'(pos);
    item.pan_neg  = !pos[28] && (pos != '0);
    item.beam_mag = delta;
  end

  assign in_ready = !f_valid || !f_keep || q_ready;
  assign q_push   = f_valid && f_keep && q_ready;
  assign q_item   = f_item;

  always_ff @(posedge clk) begin
    if (rst) begin
      f_valid <= 1'b0;
    end else if (in_ready) begin
      f_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      f_item <= item;
      f_keep <= !drop;
    end
  end

endmodule

// ===== design/lsp_fifo.sv =====
// lsp_fifo: short queue of classified points between front and back
// depends on lsp_pkg (item_t, QUEUE_DEPTH)

module lsp_fifo (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  lsp_pkg::item_t push_item,
  output logic           not_full,
  input  logic           pop,
  output logic           not_empty,
  output lsp_pkg::item_t pop_item
);
  import lsp_pkg::*;

  localparam int AW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  item_t          entries [QUEUE_DEPTH];
  logic [AW-1:0]  wr_ptr;
  logic [AW-1:0]  rd_ptr;
  logic [CW-1:0]  count;
  logic [CW-1:0]  count_next;

  assign not_full   = count != CW'(QUEUE_DEPTH);
  assign not_empty  = count != '0;
  assign pop_item   = entries[rd_ptr];
  assign count_next = count + CW'(push) - CW'(pop);

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + AW'(1);
      if (pop) rd_ptr <= rd_ptr + AW'(1);
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_item;
    end
  end

endmodule

// ===== design/lsp_trig.sv =====
// lsp_trig: pipelined sine and cosine in Q1.15 of an angle given in units of 1/DEN turn
// depends on lsp_pkg (stage counts, MAG_W); one angle per cycle while adv is high

module lsp_trig #(
  parameter int DEN = lsp_pkg::BEAMS_PER_TURN
) (
  input  logic                      clk,
  input  logic                      adv,
  input  logic [lsp_pkg::MAG_W-1:0] mag,
  input  logic                      neg,
  output logic signed [15:0]        sin_q15,
  output logic signed [15:0]        cos_q15
);
  import lsp_pkg::*;

  localparam logic [16:0] DEN_V    = 17'(DEN);
  localparam logic [31:0] HALF_DEN = 32'(DEN / 2);
  localparam logic [31:0] PI_Q30   = 32'd3373259426;
  localparam logic [30:0] Q30_ONE  = 31'h4000_0000;
  localparam int K_COS [HORNER_SLOTS] = '{132, 90, 56, 30, 12, 2};
  localparam int K_SIN [HORNER_SLOTS] = '{110, 72, 42, 20, 6, 0};

  // four steps of long division by DEN: {remainder, quotient digit}
  function automatic logic [20:0] div_digit(input logic [16:0] rem, input logic [3:0] dig);
    logic [16:0] r;
    logic [16:0] t;
    logic [3:0]  q;
    r = rem;
    q = '0;
    for (int i = 3; i >= 0; i--) begin
      t = {r[15:0], dig[i]};
      if (t >= DEN_V) begin
        t    = t - DEN_V;
        q[i] = 1'b1;
      end
      r = t;
    end
    return {r, q};
  endfunction

  // 1 - p/k floored at zero, q0 being p/k from the reciprocal, low by at most one
  function automatic logic [30:0] horner_fin(input logic [31:0] p, input logic [31:0] q0,
                                              input int k);
    logic [39:0] r;
    logic [31:0] t;
    r = 40'(p) - 40'(q0) * 40'(k);
    t = (r >= 40'(k)) ? q0 + 32'd1 : q0;
    return (t >= 32'(Q30_ONE)) ? '0 : 31'(32'(Q30_ONE) - t);
  endfunction

  function automatic logic signed [15:0] to_q15(input logic [30:0] v);
    logic [31:0] q;
    q = (32'(v) + 32'd16384) >> 15;
    return (q > 32'd32767) ? 16'sd32767 : signed'(q[15:0]);
  endfunction

  // reduction of the angle modulo one turn
  logic [16:0]      m_rem [MOD_STAGES];
  logic [MAG_W-1:0] m_mag [MOD_STAGES];
  logic             m_neg [MOD_STAGES];
  logic [20:0]      m_d   [MOD_STAGES];

  always_comb begin
    m_d[0] = div_digit(17'd0, mag[MAG_W-1 -: DIGIT_W]);
    for (int i = 1; i < MOD_STAGES; i++) begin
      m_d[i] = div_digit(m_rem[i-1], m_mag[i-1][MAG_W-1-DIGIT_W*i -: DIGIT_W]);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      m_rem[0] <= m_d[0][20:4];
      m_mag[0] <= mag;
      m_neg[0] <= neg;
      for (int i = 1; i < MOD_STAGES; i++) begin
        m_rem[i] <= m_d[i][20:4];
        m_mag[i] <= m_mag[i-1];
        m_neg[i] <= m_neg[i-1];
      end
    end
  end

  logic [16:0] f_num;

  always_ff @(posedge clk) begin
    if (adv) begin
      f_num <= (m_neg[MOD_STAGES-1] && m_rem[MOD_STAGES-1] != '0) ?
               DEN_V - m_rem[MOD_STAGES-1] : m_rem[MOD_STAGES-1];
    end
  end

  // fraction of a turn in Q32, rounded to nearest
  logic [16:0] p_rem [PHASE_STAGES];
  logic [31:0] p_q   [PHASE_STAGES];
  logic [20:0] p_d   [PHASE_STAGES];

  always_comb begin
    p_d[0] = div_digit(f_num, HALF_DEN[31 -: DIGIT_W]);
    for (int j = 1; j < PHASE_STAGES; j++) begin
      p_d[j] = div_digit(p_rem[j-1], HALF_DEN[31-DIGIT_W*j -: DIGIT_W]);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      p_rem[0] <= p_d[0][20:4];
      p_q[0]   <= {28'd0, p_d[0][3:0]};
      for (int j = 1; j < PHASE_STAGES; j++) begin
        p_rem[j] <= p_d[j][20:4];
        p_q[j]   <= {p_q[j-1][27:0], p_d[j][3:0]};
      end
    end
  end

  logic [63:0] x_prod;
  logic [30:0] xs_x;
  logic [1:0]  xs_quad;
  logic [61:0] x_sq;
  logic [30:0] x2_x;
  logic [31:0] x2_x2;
  logic [1:0]  x2_quad;

  assign x_prod = 64'(p_q[PHASE_STAGES-1][29:0]) * 64'(PI_Q30);
  assign x_sq   = 62'(xs_x) * 62'(xs_x);

  always_ff @(posedge clk) begin
    if (adv) begin
      xs_x    <= x_prod[61:31];
      xs_quad <= p_q[PHASE_STAGES-1][31:30];
      x2_x2   <= x_sq[61:30];
      x2_x    <= xs_x;
      x2_quad <= xs_quad;
    end
  end

  // horner slots, three stages each: multiply, reciprocal multiply, correct
  logic [31:0] h1_pc [HORNER_SLOTS];
  logic [31:0] h1_ps [HORNER_SLOTS];
  logic [30:0] h1_x  [HORNER_SLOTS];
  logic [31:0] h1_x2 [HORNER_SLOTS];
  logic [1:0]  h1_q  [HORNER_SLOTS];
  logic [31:0] h2_pc [HORNER_SLOTS];
  logic [31:0] h2_ps [HORNER_SLOTS];
  logic [31:0] h2_qc [HORNER_SLOTS];
  logic [31:0] h2_qs [HORNER_SLOTS];
  logic [30:0] h2_x  [HORNER_SLOTS];
  logic [31:0] h2_x2 [HORNER_SLOTS];
  logic [1:0]  h2_q  [HORNER_SLOTS];
  logic [30:0] a_c   [HORNER_SLOTS];
  logic [30:0] a_s   [HORNER_SLOTS];
  logic [30:0] a_x   [HORNER_SLOTS];
  logic [31:0] a_x2  [HORNER_SLOTS];
  logic [1:0]  a_q   [HORNER_SLOTS];

  for (genvar j = 0; j < HORNER_SLOTS; j++) begin : g_slot
    localparam int SC = 31 + $clog2(K_COS[j]);
    localparam logic [31:0] MC = 32'((64'd1 << SC) / K_COS[j]);

    logic [30:0] in_c;
    logic [30:0] in_s;
    logic [30:0] in_x;
    logic [31:0] in_x2;
    logic [1:0]  in_q;
    logic [31:0] mul_s;
    logic [62:0] prod_c;
    logic [62:0] prod_s;
    logic [63:0] rc_c;

    if (j == 0) begin : g_first
      assign in_c  = Q30_ONE;
      assign in_s  = Q30_ONE;
      assign in_x  = x2_x;
      assign in_x2 = x2_x2;
      assign in_q  = x2_quad;
    end else begin : g_next
      assign in_c  = a_c[j-1];
      assign in_s  = a_s[j-1];
      assign in_x  = a_x[j-1];
      assign in_x2 = a_x2[j-1];
      assign in_q  = a_q[j-1];
    end

    // the last sine slot multiplies by x instead of x squared
    if (K_SIN[j] == 0) begin : g_sin_mul_x
      assign mul_s = {1'b0, in_x};
    end else begin : g_sin_mul_x2
      assign mul_s = in_x2;
    end

    assign prod_c = 63'(in_x2) * 63'(in_c);
    assign prod_s = 63'(mul_s) * 63'(in_s);
    assign rc_c   = 64'(h1_pc[j]) * 64'(MC);

    always_ff @(posedge clk) begin
      if (adv) begin
        h1_pc[j] <= prod_c[61:30];
        h1_ps[j] <= prod_s[61:30];
        h1_x[j]  <= in_x;
        h1_x2[j] <= in_x2;
        h1_q[j]  <= in_q;
        h2_pc[j] <= h1_pc[j];
        h2_ps[j] <= h1_ps[j];
        h2_qc[j] <= 32'(rc_c >> SC);
        h2_x[j]  <= h1_x[j];
        h2_x2[j] <= h1_x2[j];
        h2_q[j]  <= h1_q[j];
        a_c[j]   <= horner_fin(h2_pc[j], h2_qc[j], K_COS[j]);
        a_x[j]   <= h2_x[j];
        a_x2[j]  <= h2_x2[j];
        a_q[j]   <= h2_q[j];
      end
    end

    if (K_SIN[j] == 0) begin : g_sin_final
      always_ff @(posedge clk) begin
        if (adv) begin
          h2_qs[j] <= '0;
          a_s[j]   <= h2_ps[j][30:0];
        end
      end
    end else begin : g_sin_horner
      localparam int SS = 31 + $clog2(K_SIN[j]);
      localparam logic [31:0] MS = 32'((64'd1 << SS) / K_SIN[j]);
      logic [63:0] rc_s;
      assign rc_s = 64'(h1_ps[j]) * 64'(MS);
      always_ff @(posedge clk) begin
        if (adv) begin
          h2_qs[j] <= 32'(rc_s >> SS);
          a_s[j]   <= horner_fin(h2_ps[j], h2_qs[j], K_SIN[j]);
        end
      end
    end
  end

  logic signed [15:0] sq;
  logic signed [15:0] cq;

  assign sq = to_q15(a_s[HORNER_SLOTS-1]);
  assign cq = to_q15(a_c[HORNER_SLOTS-1]);

  always_ff @(posedge clk) begin
    if (adv) begin
      unique case (a_q[HORNER_SLOTS-1])
        2'd0: begin
          sin_q15 <= sq;
          cos_q15 <= cq;
        end
        2'd1: begin
          sin_q15 <= cq;
          cos_q15 <= -sq;
        end
        2'd2: begin
          sin_q15 <= -sq;
          cos_q15 <= -cq;
        end
        default: begin
          sin_q15 <= -cq;
          cos_q15 <= sq;
        end
      endcase
    end
  end

endmodule

// ===== design/lsp_back.sv =====
// lsp_back: pops queued points, runs pan and beam trig and forms rounded x, y, z
// depends on lsp_pkg and lsp_trig; whole pipeline advances while the output is free

module lsp_back #(
  parameter int PAN_STEPS_PER_TURN = lsp_pkg::PAN_STEPS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               q_valid,
  input  lsp_pkg::item_t     q_item,
  output logic               q_pop,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [16:0] x_mm,
  output logic signed [16:0] y_mm,
  output logic signed [16:0] z_mm,
  output logic [15:0]        range_out_mm,
  output logic [12:0]        point_row,
  output logic [10:0]        point_col,
  output logic               gated_out
);
  import lsp_pkg::*;

  function automatic logic signed [16:0] round_sat(input logic signed [48:0] v, input int sh);
    logic [48:0] m;
    logic [48:0] r;
    m = v[48] ? 49'(-v) : 49'(v);
    r = (m + (49'd1 << (sh - 1))) >> sh;
    if (r > 49'(COORD_LIMIT)) r = 49'(COORD_LIMIT);
    return v[48] ? -signed'(r[16:0]) : signed'(r[16:0]);
  endfunction

  logic adv;
  assign adv   = !out_valid || out_ready;
  assign q_pop = adv && q_valid;

  logic signed [15:0] s_pan;
  logic signed [15:0] c_pan;
  logic signed [15:0] s_beam;
  logic signed [15:0] c_beam;

  lsp_trig #(.DEN(PAN_STEPS_PER_TURN)) u_pan_trig (
    .clk     (clk),
    .adv     (adv),
    .mag     (q_item.pan_mag),
    .neg     (q_item.pan_neg),
    .sin_q15 (s_pan),
    .cos_q15 (c_pan)
  );

  lsp_trig #(.DEN(BEAMS_PER_TURN)) u_beam_trig (
    .clk     (clk),
    .adv     (adv),
    .mag     (MAG_W'(q_item.beam_mag)),
    .neg     (1'b0),
    .sin_q15 (s_beam),
    .cos_q15 (c_beam)
  );

  // point data travels beside the trig units
  logic [TRIG_LAT-1:0] sb_valid;
  item_t               sb_item [TRIG_LAT];

  always_ff @(posedge clk) begin
    if (rst) begin
      sb_valid <= '0;
    end else if (adv) begin
      sb_valid <= {sb_valid[TRIG_LAT-2:0], q_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sb_item[0] <= q_item;
      for (int i = 1; i < TRIG_LAT; i++) begin
        sb_item[i] <= sb_item[i-1];
      end
    end
  end

  logic               a_valid;
  item_t              a_item;
  logic signed [32:0] a_p1;
  logic signed [32:0] a_pz;
  logic signed [15:0] a_cp;
  logic signed [15:0] a_sp;
  logic               b_valid;
  item_t              b_item;
  logic signed [48:0] b_px;
  logic signed [48:0] b_py;
  logic signed [32:0] b_pz;
  logic signed [16:0] rng;

  assign rng = signed'({1'b0, sb_item[TRIG_LAT-1].range_mm});

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid   <= 1'b0;
      b_valid   <= 1'b0;
      out_valid <= 1'b0;
    end else if (adv) begin
      a_valid   <= sb_valid[TRIG_LAT-1];
      b_valid   <= a_valid;
      out_valid <= b_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a_item <= sb_item[TRIG_LAT-1];
      a_p1   <= rng * s_beam;
      a_pz   <= rng * c_beam;
      // second half of the image looks the other way round
      a_cp   <= sb_item[TRIG_LAT-1].second ? -c_pan : c_pan;
      a_sp   <= sb_item[TRIG_LAT-1].second ? -s_pan : s_pan;

      b_item <= a_item;
      b_px   <= a_p1 * a_cp;
      b_py   <= a_p1 * a_sp;
      b_pz   <= a_pz;

      point_row <= b_item.prow;
      point_col <= b_item.col;
      gated_out <= b_item.gated;
      if (b_item.gated) begin
        x_mm         <= '0;
        y_mm         <= '0;
        z_mm         <= '0;
        range_out_mm <= '0;
      end else begin
        x_mm         <= round_sat(b_px, 30);
        y_mm         <= round_sat(b_py, 30);
        z_mm         <= round_sat(49'(b_pz), 15);
        range_out_mm <= b_item.range_mm;
      end
    end
  end

endmodule

// ===== design/lidar_scan_to_point_converter.sv =====
// lidar_scan_to_point_converter: top level with the register port, front, queue and back
// depends on lsp_pkg, lsp_front, lsp_fifo, lsp_back (and lsp_trig below it)
//
// Usage:
//   Range requests enter on in_valid/in_ready with range_mm, beam_index and
//   row_index. Each request either yields one point on out_valid/out_ready or,
//   for the front beam and beams outside the min/max window or above MAX_BEAM_INDEX, nothing.
//   Registers are written through the APB-style port at byte address 4*index;
//   write them only while no request is in flight.
//   Throughput: one request per cycle while out_ready is high. The front
//   register, a four-entry queue and the fully pipelined trig units each
//   take a new item every cycle while nothing stalls. A point passes the
//   front register, the queue and the trig units (digit-serial angle reduction
//   and phase division, then the Horner stages of the sine and cosine series).
//   Stall: when out_ready is low the back pipeline holds, the queue fills and
//   then in_ready drops; nothing is lost.
//   Reset (rst, synchronous): registers return to their defaults (rows 1,
//   front beam 540, window 0 to 1080, gating on); queue and pipeline empty.

module lidar_scan_to_point_converter #(
  parameter int MAX_BEAM_INDEX     = lsp_pkg::MAX_BEAM_INDEX_DEF,
  parameter int PAN_STEPS_PER_TURN = lsp_pkg::PAN_STEPS_DEF,
  parameter int MAX_ROWS           = lsp_pkg::MAX_ROWS_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [lsp_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [15:0]                range_mm,
  input  logic [10:0]                beam_index,
  input  logic [11:0]                row_index,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic signed [16:0]         x_mm,
  output logic signed [16:0]         y_mm,
  output logic signed [16:0]         z_mm,
  output logic [15:0]                range_out_mm,
  output logic [12:0]                point_row,
  output logic [10:0]                point_col,
  output logic                       gated_out
);
  import lsp_pkg::*;

  cfg_t     cfg;
  reg_idx_t reg_idx;
  logic     cfg_wr;

  assign pready  = 1'b1;
  assign reg_idx = reg_idx_t'(paddr[4:2]);
  assign cfg_wr  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.start_pan_steps    <= '0;
      cfg.pan_step_increment <= '0;
      cfg.rows_in_scan       <= 13'd1;
      cfg.front_beam         <= 11'd540;
      cfg.min_beam           <= 11'd0;
      cfg.max_beam           <= 11'd1080;
      cfg.gate_enable        <= 1'b1;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        REG_START_PAN: cfg.start_pan_steps    <= signed'(pwdata[15:0]);
        REG_PAN_INC:   cfg.pan_step_increment <= signed'(pwdata[15:0]);
        REG_ROWS:      cfg.rows_in_scan       <= pwdata[12:0];
        REG_FRONT:     cfg.front_beam         <= pwdata[10:0];
        REG_MIN_BEAM:  cfg.min_beam           <= pwdata[10:0];
        REG_MAX_BEAM:  cfg.max_beam           <= pwdata[10:0];
        REG_GATE_EN:   cfg.gate_enable        <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_START_PAN: prdata = {16'd0, cfg.start_pan_steps};
      REG_PAN_INC:   prdata = {16'd0, cfg.pan_step_increment};
      REG_ROWS:      prdata = {19'd0, cfg.rows_in_scan};
      REG_FRONT:     prdata = {21'd0, cfg.front_beam};
      REG_MIN_BEAM:  prdata = {21'd0, cfg.min_beam};
      REG_MAX_BEAM:  prdata = {21'd0, cfg.max_beam};
      REG_GATE_EN:   prdata = {31'd0, cfg.gate_enable};
      default:       prdata = '0;
    endcase
  end

  logic  q_push;
  logic  q_not_full;
  logic  q_pop;
  logic  q_not_empty;
  item_t q_in;
  item_t q_out;

  lsp_front #(
    .MAX_BEAM_INDEX (MAX_BEAM_INDEX),
    .MAX_ROWS       (MAX_ROWS)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .range_mm   (range_mm),
    .beam_index (beam_index),
    .row_index  (row_index),
    .cfg        (cfg),
    .q_ready    (q_not_full),
    .q_push     (q_push),
    .q_item     (q_in)
  );

  lsp_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_item (q_in),
    .not_full  (q_not_full),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .pop_item  (q_out)
  );

  lsp_back #(
    .PAN_STEPS_PER_TURN (PAN_STEPS_PER_TURN)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .q_valid      (q_not_empty),
    .q_item       (q_out),
    .q_pop        (q_pop),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .x_mm         (x_mm),
    .y_mm         (y_mm),
    .z_mm         (z_mm),
    .range_out_mm (range_out_mm),
    .point_row    (point_row),
    .point_col    (point_col),
    .gated_out    (gated_out)
  );

  // a gated point carries no coordinates
  a_gated_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && gated_out |-> x_mm == '0 && y_mm == '0 && z_mm == '0 && range_out_mm == '0)
    else $error("gated point with non-zero payload");

  // with gating on, a passed point lies strictly inside the range window
  a_gate_window: assert property (@(posedge clk) disable iff (rst)
    out_valid && !gated_out && cfg.gate_enable |->
      range_out_mm > GATE_LOW_MM && range_out_mm < GATE_HIGH_MM)
    else $error("point outside range window passed the gate");

  // the queue is never pushed while full
  a_queue_push: assert property (@(posedge clk) disable iff (rst)
    q_push |-> q_not_full)
    else $error("push into full queue");

endmodule

// ===== bench/tb_top.sv =====
// tb_top: self-checking bench for the lidar range-to-point converter
// depends on lsp_pkg and lidar_scan_to_point_converter; predicts each point in-bench

module tb_top;
  import lsp_pkg::*;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [15:0] range_mm = '0;
  logic [10:0] beam_index = '0;
  logic [11:0] row_index = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [16:0] x_mm, y_mm, z_mm;
  logic [15:0] range_out_mm;
  logic [12:0] point_row;
  logic [10:0] point_col;
  logic gated_out;

  lidar_scan_to_point_converter uut (.*);

  always #5 clk = ~clk;

  typedef struct packed {
    logic signed [16:0] x, y, z;
    logic [15:0] rng;
    logic [12:0] prow;
    logic [10:0] col;
    logic gated;
  } point_t;

  typedef struct {
    logic [15:0] rng;
    logic [10:0] beam;
    logic [11:0] row;
    bit typed;
    point_t pt;
  } stim_t;

  point_t expected_points[$];
  cfg_t cfg;
  int errors = 0;
  int cycles = 0;
  bit hold_done = 1'b0;

  task automatic report(input string what, input longint got, input longint want);
    $display("mismatch %s: got %0d want %0d", what, got, want);
    errors++;
  endtask

  // one horner stage of the series, floored at zero
  function automatic longint unsigned series_stage(longint unsigned acc, longint unsigned x2,
                                                   longint unsigned k);
    longint unsigned t;
    t = ((x2 * acc) >> 30) / k;
    return (t >= (64'd1 << 30)) ? 64'd0 : (64'd1 << 30) - t;
  endfunction

  function automatic int q15_of(longint unsigned v);
    longint unsigned q;
    q = (v + 16384) >> 15;
    return (q > 32767) ? 32767 : int'(q);
  endfunction

  function automatic void sin_cos(longint unsigned num, longint unsigned den,
                                  output int s, output int c);
    longint unsigned phase, r, x, x2, a, sv;
    int sq, cq;
    phase = (((num << 32) + den / 2) / den) & 64'hFFFF_FFFF;
    r = phase & ((64'd1 << 30) - 1);
    x = (r * 64'd3373259426) >> 31;
    x2 = (x * x) >> 30;
    a = 64'd1 << 30;
    a = series_stage(a, x2, 110); a = series_stage(a, x2, 72);
    a = series_stage(a, x2, 42);  a = series_stage(a, x2, 20);
    a = series_stage(a, x2, 6);
    sv = (x * a) >> 30;
    a = 64'd1 << 30;
    a = series_stage(a, x2, 132); a = series_stage(a, x2, 90);
    a = series_stage(a, x2, 56);  a = series_stage(a, x2, 30);
    a = series_stage(a, x2, 12);  a = series_stage(a, x2, 2);
    sq = q15_of(sv);
    cq = q15_of(a);
    case (phase >> 30)
      0: begin s = sq; c = cq; end
      1: begin s = cq; c = -sq; end
      2: begin s = -sq; c = -cq; end
      default: begin s = -cq; c = sq; end
    endcase
  endfunction

  function automatic logic signed [16:0] round_clip(longint v, int sh);
    longint unsigned m;
    m = (v < 0) ? -v : v;
    m = (m + (64'd1 << (sh - 1))) >> sh;
    if (m > 65535) m = 65535;
    return 17'((v < 0) ? -longint'(m) : longint'(m));
  endfunction

  // returns 0 when the beam yields no point
  function automatic bit convert_point(logic [15:0] rng, logic [10:0] beam, logic [11:0] row,
                                       output point_t p);
    int unsigned delta, rows, prow;
    longint pos, nm;
    int sp, cp, sb, cb;
    bit second;
    p = '0;
    if (beam == cfg.front_beam || beam < cfg.min_beam || beam > cfg.max_beam || beam > 1080)
      return 1'b0;
    second = beam > cfg.front_beam;
    delta = second ? beam - cfg.front_beam : cfg.front_beam - beam;
    rows = (cfg.rows_in_scan > 4096) ? 4096 : cfg.rows_in_scan;
    prow = second ? row + rows : row;
    p.prow = 13'((prow > 8191) ? 8191 : prow);
    p.col = 11'(delta - 1);
    pos = longint'(cfg.start_pan_steps) + longint'(row) * longint'(cfg.pan_step_increment);
    nm = (-pos) % 7000;
    if (nm < 0) nm += 7000;
    sin_cos(nm, 7000, sp, cp);
    if (second) begin
      sp = -sp;
      cp = -cp;
    end
    sin_cos(delta % 1440, 1440, sb, cb);
    if (cfg.gate_enable && !(rng > 100 && rng < 30000)) begin
      p.gated = 1'b1;
      return 1'b1;
    end
    p.x = round_clip(longint'(rng) * sb * cp, 30);
    p.y = round_clip(longint'(rng) * sb * sp, 30);
    p.z = round_clip(longint'(rng) * cb, 15);
    p.rng = rng;
    return 1'b1;
  endfunction

  task automatic write_reg(input reg_idx_t idx, input logic [31:0] val);
    @(negedge clk);
    psel <= 1'b1; pwrite <= 1'b1; paddr <= ADDR_W'(4 * idx); pwdata <= val;
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    case (idx)
      REG_START_PAN: cfg.start_pan_steps = val[15:0];
      REG_PAN_INC:   cfg.pan_step_increment = val[15:0];
      REG_ROWS:      cfg.rows_in_scan = val[12:0];
      REG_FRONT:     cfg.front_beam = val[10:0];
      REG_MIN_BEAM:  cfg.min_beam = val[10:0];
      REG_MAX_BEAM:  cfg.max_beam = val[10:0];
      default:       cfg.gate_enable = val[0];
    endcase
  endtask

  // valid stays up between requests sent with no gap
  task automatic send_request(input stim_t st);
    point_t p;
    int gap;
    gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 19);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    range_mm <= st.rng; beam_index <= st.beam; row_index <= st.row;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (st.typed) begin
      expected_points.insert(expected_points.size(), st.pt);
    end else if (convert_point(st.rng, st.beam, st.row, p)) begin
      expected_points.insert(expected_points.size(), p);
    end
    @(negedge clk);
  endtask

  // let the pipeline drain before touching a register
  task automatic drain;
    in_valid <= 1'b0;
    while (expected_points.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  task automatic random_phase(input int n);
    stim_t st;
    for (int i = 0; i < n; i++) begin
      st.typed = 1'b0;
      case ($urandom_range(0, 5))
        0: st.rng = 16'($urandom_range(0, 65535));
        1: st.rng = 16'($urandom_range(0, 120));
        2: st.rng = 16'($urandom_range(29980, 30020));
        default: st.rng = 16'($urandom_range(101, 29999));
      endcase
      st.beam = ($urandom_range(0, 9) == 0) ? 11'($urandom_range(0, 2047)) :
                                              11'($urandom_range(0, 1080));
      st.row = 12'($urandom_range(0, 4095));
      send_request(st);
    end
  endtask

  // receiver: random stalls, with one long hold-off early on
  initial begin
    int wait_cycles;
    @(negedge clk);
    forever begin
      if (!hold_done && cycles > 400) begin
        out_ready <= 1'b0;
        repeat (200) @(negedge clk);
        hold_done = 1'b1;
      end
      wait_cycles = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 19);
      if (wait_cycles > 0) begin
        out_ready <= 1'b0;
        repeat (wait_cycles) @(negedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      @(negedge clk);
    end
  end

  always @(posedge clk) begin
    point_t want;
    cycles <= cycles + 1;
    if (!rst && out_valid && out_ready) begin
      if (expected_points.size() == 0) begin
        report("point with no request waiting", 1, 0);
      end else begin
        want = expected_points.pop_front();
        if (x_mm !== want.x) report("x_mm", x_mm, want.x);
        if (y_mm !== want.y) report("y_mm", y_mm, want.y);
        if (z_mm !== want.z) report("z_mm", z_mm, want.z);
        if (range_out_mm !== want.rng) report("range_out_mm", range_out_mm, want.rng);
        if (point_row !== want.prow) report("point_row", point_row, want.prow);
        if (point_col !== want.col) report("point_col", point_col, want.col);
        if (gated_out !== want.gated) report("gated_out", gated_out, want.gated);
      end
    end
  end

  always @(posedge clk) begin
    if (cycles > 400000) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  stim_t directed[$];

  function automatic stim_t row_of(logic [15:0] r, logic [10:0] b, logic [11:0] w);
    stim_t s;
    s.rng = r; s.beam = b; s.row = w; s.typed = 1'b0; s.pt = '0;
    return s;
  endfunction

  initial begin
    stim_t s;
    cfg = '{start_pan_steps: 0, pan_step_increment: 0, rows_in_scan: 1, front_beam: 540,
            min_beam: 0, max_beam: 1080, gate_enable: 1};
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // typed rows: gated points with known row and column
    s = row_of(16'd0, 11'd0, 12'd0); s.typed = 1;
    s.pt = '{x: 0, y: 0, z: 0, rng: 0, prow: 0, col: 539, gated: 1};
    directed.insert(directed.size(), s);
    s = row_of(16'hFFFF, 11'd1080, 12'd4095); s.typed = 1;
    s.pt = '{x: 0, y: 0, z: 0, rng: 0, prow: 4096, col: 539, gated: 1};
    directed.insert(directed.size(), s);
    s = row_of(16'd100, 11'd541, 12'd7); s.typed = 1;
    s.pt = '{x: 0, y: 0, z: 0, rng: 0, prow: 8, col: 0, gated: 1};
    directed.insert(directed.size(), s);
    s = row_of(16'd30000, 11'd539, 12'd3); s.typed = 1;
    s.pt = '{x: 0, y: 0, z: 0, rng: 0, prow: 3, col: 0, gated: 1};
    directed.insert(directed.size(), s);
    // front beam, out of window, and a spread of plain points
    directed.insert(directed.size(), row_of(16'd5000, 11'd540, 12'd0));
    directed.insert(directed.size(), row_of(16'd5000, 11'd2047, 12'd0));
    directed.insert(directed.size(), row_of(16'd101, 11'd0, 12'd0));
    directed.insert(directed.size(), row_of(16'd29999, 11'd1080, 12'd4095));
    directed.insert(directed.size(), row_of(16'd29999, 11'd180, 12'd100));
    directed.insert(directed.size(), row_of(16'd12345, 11'd900, 12'd2048));
    directed.insert(directed.size(), row_of(16'd2000, 11'd720, 12'd1));
    foreach (directed[i]) send_request(directed[i]);
    random_phase(120);
    drain();

    // gate off, extremes of pan, big rows, front at 0
    write_reg(REG_GATE_EN, 32'd0);
    write_reg(REG_START_PAN, 32'hFFFF_8000);
    write_reg(REG_PAN_INC, 32'h0000_7FFF);
    write_reg(REG_ROWS, 32'd8191);
    write_reg(REG_FRONT, 32'd0);
    send_request(row_of(16'hFFFF, 11'd1080, 12'd4095));
    send_request(row_of(16'd0, 11'd1, 12'd0));
    random_phase(150);
    drain();

    write_reg(REG_START_PAN, 32'h0000_7FFF);
    write_reg(REG_PAN_INC, 32'hFFFF_8000);
    write_reg(REG_ROWS, 32'd4096);
    write_reg(REG_FRONT, 32'd1080);
    write_reg(REG_MIN_BEAM, 32'd100);
    write_reg(REG_MAX_BEAM, 32'd1000);
    random_phase(150);
    drain();

    write_reg(REG_GATE_EN, 32'd1);
    write_reg(REG_START_PAN, 32'd1234);
    write_reg(REG_PAN_INC, 32'hFFFF_FFF9);
    write_reg(REG_ROWS, 32'd1);
    write_reg(REG_FRONT, 32'd540);
    write_reg(REG_MIN_BEAM, 32'd0);
    write_reg(REG_MAX_BEAM, 32'd1080);
    random_phase(150);
    drain();

    write_reg(REG_FRONT, 32'd2047);
    write_reg(REG_MIN_BEAM, 32'd1080);
    write_reg(REG_MAX_BEAM, 32'd0);
    random_phase(10);
    drain();
    write_reg(REG_MIN_BEAM, 32'd0);
    write_reg(REG_MAX_BEAM, 32'd2047);
    write_reg(REG_PAN_INC, 32'd35);
    write_reg(REG_ROWS, 32'd200);
    random_phase(150);
    drain();

    if (errors == 0 && expected_points.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end
endmodule

// ===== sim.f =====
design/lsp_pkg.sv
design/lsp_front.sv
design/lsp_fifo.sv
design/lsp_trig.sv
design/lsp_back.sv
design/lidar_scan_to_point_converter.sv
bench/tb_top.sv
